// ===== hw/rtl/rrqq_pkg.sv =====
// rrqq_pkg: shared constants, codes and payload/command types for the
// round-robin quantum queue. No dependencies.
package rrqq_pkg;

  // sizing
  localparam int unsigned QueueDepth = 64;
  localparam int unsigned BurstBits  = 16;
  localparam int unsigned IdxBits    = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntBits    = $clog2(QueueDepth + 1);
  localparam int unsigned SumBits    = BurstBits + IdxBits;
  localparam int unsigned FracBits   = 8;
  localparam int unsigned DivBits    = SumBits + FracBits;
  localparam int unsigned DivCntBits = $clog2(DivBits + 1);

  // fixed field widths
  localparam int unsigned OpBits     = 2;
  localparam int unsigned StatusBits = 3;
  localparam int unsigned TimeBits   = 16;
  localparam int unsigned QuantBits  = 16;
  localparam int unsigned AvgBits    = 24;
  localparam int unsigned CmpBits    = (BurstBits > QuantBits) ? BurstBits : QuantBits;

  // opcodes
  localparam logic [OpBits-1:0] OpAdd      = 2'd0;
  localparam logic [OpBits-1:0] OpDispatch = 2'd1;
  localparam logic [OpBits-1:0] OpQuery    = 2'd2;
  localparam logic [OpBits-1:0] OpInvalid  = 2'd3;

  // result status codes
  localparam logic [StatusBits-1:0] StOk      = 3'd0;
  localparam logic [StatusBits-1:0] StEmpty   = 3'd1;
  localparam logic [StatusBits-1:0] StFull    = 3'd2;
  localparam logic [StatusBits-1:0] StBadOp   = 3'd3;
  localparam logic [StatusBits-1:0] StIgnored = 3'd4;

  // request payload
  typedef struct packed {
    logic [OpBits-1:0]   opcode;
    logic [TimeBits-1:0] burst_time;
  } req_t;

  // result payload
  typedef struct packed {
    logic [StatusBits-1:0] status;
    logic [TimeBits-1:0]   served_time;
    logic                  job_finished;
    logic [AvgBits-1:0]    average_q8;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic div_start;
    logic commit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/rrqq_ram.sv =====
// rrqq_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrqq_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/rrqq_ctrl.sv =====
// rrqq_ctrl: sequencing state machine for the quantum queue.
// Depends on rrqq_pkg (cmd_t, sts_t).
module rrqq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rrqq_pkg::sts_t sts_i,
  output rrqq_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    CtlIdle = 3'b001,
    CtlExec = 3'b010,
    CtlDiv  = 3'b100
  } ctl_state_e;

  ctl_state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_ready_o    = 1'b0;
    unique case (state_q)
      CtlIdle: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = CtlExec;
        end
      end
      CtlExec: begin
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = CtlDiv;
        end else if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = CtlIdle;
        end
      end
      CtlDiv: begin
        if (sts_i.div_done && sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = CtlIdle;
        end
      end
      default: begin
        state_d = CtlIdle;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CtlIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/rrqq_dp.sv =====
// rrqq_dp: queue pointers, running sum, serial divider, job store and
// result register. Depends on rrqq_pkg and rrqq_ram.
module rrqq_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [rrqq_pkg::QuantBits-1:0]  cfg_data_i,
  input  rrqq_pkg::req_t                  in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output rrqq_pkg::rsp_t                  out_rsp_o,
  input  rrqq_pkg::cmd_t                  cmd_i,
  output rrqq_pkg::sts_t                  sts_o
);

  localparam int unsigned IdxBits  = rrqq_pkg::IdxBits;
  localparam int unsigned CntBits  = rrqq_pkg::CntBits;
  localparam int unsigned SumBits  = rrqq_pkg::SumBits;
  localparam int unsigned DivBits  = rrqq_pkg::DivBits;
  localparam int unsigned BurstBits = rrqq_pkg::BurstBits;
  localparam int unsigned CmpBits  = rrqq_pkg::CmpBits;

  logic [rrqq_pkg::QuantBits-1:0] quant_q;
  rrqq_pkg::req_t                 req_q;
  logic [IdxBits-1:0]             head_q, head_d;
  logic [IdxBits-1:0]             tail_q, tail_d;
  logic [CntBits-1:0]             count_q, count_d;
  logic [SumBits-1:0]             sum_q, sum_d;
  logic [DivBits-1:0]             dq_q;
  logic [CntBits-1:0]             rem_q;
  logic [rrqq_pkg::DivCntBits-1:0] div_cnt_q;
  logic [CntBits:0]               rem_sh;
  logic                           rem_ge;
  rrqq_pkg::rsp_t                 out_q, rsp;
  logic                           out_valid_q;
  logic                           out_free;

  logic [BurstBits-1:0] job, add_burst, push_data;
  logic [CmpBits-1:0]   job_ext, q_ext, served;
  logic [SumBits-1:0]   sum_inc, sum_dec;
  logic                 do_push, do_pop;

  function automatic logic [IdxBits-1:0] next_slot(input logic [IdxBits-1:0] i);
    logic [IdxBits-1:0] r;
    if (i == IdxBits'(rrqq_pkg::QueueDepth - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

  // job store, read at the head on every accept
  rrqq_ram #(
    .Width (BurstBits),
    .Depth (rrqq_pkg::QueueDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit & do_push),
    .waddr_i (tail_q),
    .wdata_i (push_data),
    .re_i    (cmd_i.accept),
    .raddr_i (head_q),
    .rdata_o (job)
  );

  // quantum register, zero acts as one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quant_q <= rrqq_pkg::QuantBits'(1);
    end else if (cfg_valid_i) begin
      quant_q <= cfg_data_i;
    end
  end

  assign q_ext = (quant_q == '0) ? CmpBits'(1) : CmpBits'(quant_q);
  assign job_ext = CmpBits'(job);
  assign add_burst = BurstBits'(req_q.burst_time);

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= in_req_i;
    end
  end

  // result and queue update decode
  always_comb begin
    rsp       = '0;
    rsp.status = rrqq_pkg::StOk;
    do_push   = 1'b0;
    do_pop    = 1'b0;
    push_data = add_burst;
    served    = '0;
    sum_inc   = '0;
    sum_dec   = '0;
    case (req_q.opcode)
      rrqq_pkg::OpAdd: begin
        if (add_burst == '0) begin
          rsp.status = rrqq_pkg::StIgnored;
        end else if (count_q == CntBits'(rrqq_pkg::QueueDepth)) begin
          rsp.status = rrqq_pkg::StFull;
        end else begin
          do_push = 1'b1;
          sum_inc = SumBits'(add_burst);
        end
      end
      rrqq_pkg::OpDispatch: begin
        if (count_q == '0) begin
          rsp.status = rrqq_pkg::StEmpty;
        end else begin
          do_pop = 1'b1;
          if (job_ext > q_ext) begin
            served    = q_ext;
            do_push   = 1'b1;
            push_data = BurstBits'(job_ext - q_ext);
          end else begin
            served           = job_ext;
            rsp.job_finished = 1'b1;
          end
          sum_dec         = SumBits'(served);
          rsp.served_time = rrqq_pkg::TimeBits'(served);
        end
      end
      rrqq_pkg::OpQuery: begin
        if (count_q == '0) begin
          rsp.status = rrqq_pkg::StEmpty;
        end else begin
          rsp.average_q8 = rrqq_pkg::AvgBits'(dq_q);
        end
      end
      default: begin
        rsp.status = rrqq_pkg::StBadOp;
      end
    endcase
  end

  // next queue state
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    sum_d   = sum_q;
    if (cmd_i.commit) begin
      if (do_pop) begin
        head_d = next_slot(head_q);
      end
      if (do_push) begin
        tail_d = next_slot(tail_q);
      end
      if (do_push && !do_pop) begin
        count_d = count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_d = count_q - 1'b1;
      end
      sum_d = sum_q + sum_inc - sum_dec;
    end
  end

  // queue state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      sum_q   <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

  // restoring divider, one quotient bit a cycle
  assign rem_sh = {rem_q, dq_q[DivBits-1]};
  assign rem_ge = (rem_sh >= {1'b0, count_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      div_cnt_q <= rrqq_pkg::DivCntBits'(DivBits);
    end else if (div_cnt_q != '0) begin
      div_cnt_q <= div_cnt_q - 1'b1;
    end
  end

  // remainder stays below the count, so its top bit is always clear
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dq_q  <= {sum_q, rrqq_pkg::FracBits'(0)};
      rem_q <= '0;
    end else if (div_cnt_q != '0) begin
      dq_q  <= {dq_q[DivBits-2:0], rem_ge};
      rem_q <= rem_ge ? CntBits'(rem_sh - {1'b0, count_q}) : rem_sh[CntBits-1:0];
    end
  end

  // output register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // status to the controller
  assign sts_o.need_div = (req_q.opcode == rrqq_pkg::OpQuery) && (count_q != '0) &&
                          (div_cnt_q == '0);
  assign sts_o.div_done = (div_cnt_q == '0);
  assign sts_o.out_free = out_free;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(rrqq_pkg::QueueDepth))
    else $error("job count beyond queue depth");

  a_empty_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> ((sum_q == '0) && (head_q == tail_q)))
    else $error("empty queue with stale sum or pointers");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> out_free)
    else $error("result committed over an untaken result");

endmodule

// ===== hw/rtl/round_robin_quantum_queue.sv =====
// Round-robin job queue with a time quantum: add, dispatch and average query.
// Add and dispatch: the request is registered, then the execute state commits the result
// to the output register once it is free. A non-empty average query first runs the
// serial divider. No new request is taken until the result is committed.
// A pending result sits in an output register while the next request is taken.
// Reset clears pointers, count and sum and sets the quantum to 1; the store is not cleared.
module round_robin_quantum_queue (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rrqq_pkg::QuantBits-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  rrqq_pkg::req_t                 in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output rrqq_pkg::rsp_t                 out_rsp_o
);

  rrqq_pkg::cmd_t cmd;
  rrqq_pkg::sts_t sts;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  // controller
  rrqq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  rrqq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
